>>> rtl/ptsc_pkg.sv
// ptsc_pkg: shared constants, types and helpers for the pwm timer setting calculator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ptsc_pkg;

  localparam int unsigned CLOCK_HZ   = 72000000;
  localparam int unsigned FREQ_MAX   = 100000;
  localparam int unsigned DUTY_MAX   = 100;
  localparam int unsigned PERIOD_MIN = 100;

  // band edges and prescaler choices
  localparam int unsigned BAND0_TOP = 100;
  localparam int unsigned BAND1_TOP = 1000;
  localparam int unsigned BAND2_TOP = 10000;
  localparam int unsigned PSC_BAND0 = 7199;
  localparam int unsigned PSC_BAND1 = 719;
  localparam int unsigned PSC_BAND2 = 71;
  localparam int unsigned PSC_BAND3 = 7;

  // timer input clock after the prescaler, worked out at elaboration
  localparam int unsigned NUM_BAND0 = CLOCK_HZ / (PSC_BAND0 + 1);
  localparam int unsigned NUM_BAND1 = CLOCK_HZ / (PSC_BAND1 + 1);
  localparam int unsigned NUM_BAND2 = CLOCK_HZ / (PSC_BAND2 + 1);
  localparam int unsigned NUM_BAND3 = CLOCK_HZ / (PSC_BAND3 + 1);

  localparam int unsigned SEL_W    = 1;
  localparam int unsigned FREQ_IN_W = 20;
  localparam int unsigned DUTY_IN_W = 8;
  localparam int unsigned PSC_W    = 13;
  localparam int unsigned PERIOD_W = 14;
  localparam int unsigned CMP_W    = 14;

  localparam int unsigned FREQ_W   = 17;  // clamped frequency
  localparam int unsigned DUTY_W   = 7;   // clamped duty
  localparam int unsigned NUM_W    = 24;  // largest dividend
  localparam int unsigned QUO_W    = 14;  // quotient stays below 2**QUO_W
  localparam int unsigned DSH_W    = FREQ_W + QUO_W - 1;
  localparam int unsigned DIV_STEPS = QUO_W;

  localparam int unsigned PROD_W   = PERIOD_W + DUTY_W;

  // divide by 100: floor(x / 100) = (x * RECIP_M) >> RECIP_SH for x < 2**20
  localparam int unsigned RECIP_SH = 26;
  localparam int unsigned RECIP_M  = ((1 << RECIP_SH) + DUTY_MAX - 1) / DUTY_MAX;
  localparam int unsigned RECIP_W  = 20;
  localparam int unsigned RMUL_W   = PROD_W + RECIP_W;

  // word handed from cell to cell
  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [PSC_W-1:0] psc;
    logic [DUTY_W-1:0] duty;
    logic [NUM_W-1:0] rem;
    logic [DSH_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
  } ptsc_word_t;

endpackage : ptsc_pkg

>>> rtl/pwm_timer_setting_calculator_top.sv
// pwm_timer_setting_calculator_top: prescaler, period and compare values for a 72 MHz pwm timer
// depends on ptsc_pkg, ptsc_front, ptsc_div_cell, ptsc_back
//
//   channel   | handshake                 | words carried
//   ----------+---------------------------+----------------------------------------------
//   request   | start, busy (always low)  | timer_sel_i, freq_request_i, duty_request_i
//   result    | done_o, one cycle wide    | timer_out_sel_o, prescale_value_o,
//             |                           | period_value_o, compare_value_o
//
// one request word is taken every cycle; each result shows on done_o in request order
// stages: clamp and band stage, 14 divider cells (one quotient bit each), then
// the period floor with duty product and the divide-by-100 output stage
// reset clears only the valid bits along the row; payload registers are left as they are
// the receiver cannot hold results off, so the row never stalls and busy stays low
`timescale 1ns / 1ps

module pwm_timer_setting_calculator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ptsc_pkg::SEL_W-1:0]          timer_sel_i,
  input  logic [ptsc_pkg::FREQ_IN_W-1:0]      freq_request_i,
  input  logic [ptsc_pkg::DUTY_IN_W-1:0]      duty_request_i,
  output logic                                done_o,
  output logic [ptsc_pkg::SEL_W-1:0]          timer_out_sel_o,
  output logic [ptsc_pkg::PSC_W-1:0]          prescale_value_o,
  output logic [ptsc_pkg::PERIOD_W-1:0]       period_value_o,
  output logic [ptsc_pkg::CMP_W-1:0]          compare_value_o
);
  import ptsc_pkg::*;

  // valid bit and word at each joint of the cell row
  logic       row_valid [DIV_STEPS+1];
  ptsc_word_t row_word  [DIV_STEPS+1];
  logic       accept;

  // the row never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // clamp, band pick and divider load
  ptsc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (accept),
    .timer_sel_i    (timer_sel_i),
    .freq_request_i (freq_request_i),
    .duty_request_i (duty_request_i),
    .valid_o        (row_valid[0]),
    .word_o         (row_word[0])
  );

  // row of division cells, quotient grows by one bit per cell
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    ptsc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (row_valid[g]),
      .word_i  (row_word[g]),
      .valid_o (row_valid[g+1]),
      .word_o  (row_word[g+1])
    );
  end

  // period floor, compare value and output register
  ptsc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (row_valid[DIV_STEPS]),
    .word_i           (row_word[DIV_STEPS]),
    .done_o           (done_o),
    .timer_out_sel_o  (timer_out_sel_o),
    .prescale_value_o (prescale_value_o),
    .period_value_o   (period_value_o),
    .compare_value_o  (compare_value_o)
  );

endmodule : pwm_timer_setting_calculator_top

>>> rtl/ptsc_front.sv
// ptsc_front: clamps the request, picks the frequency band and loads the divider word
// depends on ptsc_pkg
`timescale 1ns / 1ps

module ptsc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [ptsc_pkg::SEL_W-1:0]          timer_sel_i,
  input  logic [ptsc_pkg::FREQ_IN_W-1:0]      freq_request_i,
  input  logic [ptsc_pkg::DUTY_IN_W-1:0]      duty_request_i,
  output logic                                valid_o,
  output ptsc_pkg::ptsc_word_t                word_o
);
  import ptsc_pkg::*;

  logic [FREQ_W-1:0] freq_c;
  logic [DUTY_W-1:0] duty_c;
  ptsc_word_t        word_d, word_q;
  logic              valid_q;

  always_comb begin
    // clamp to 1..FREQ_MAX and duty to DUTY_MAX
    if (freq_request_i == '0) begin
      freq_c = FREQ_W'(1);
    end else if (freq_request_i > FREQ_IN_W'(FREQ_MAX)) begin
      freq_c = FREQ_W'(FREQ_MAX);
    end else begin
      freq_c = freq_request_i[FREQ_W-1:0];
    end
    if (duty_request_i > DUTY_IN_W'(DUTY_MAX)) begin
      duty_c = DUTY_W'(DUTY_MAX);
    end else begin
      duty_c = duty_request_i[DUTY_W-1:0];
    end

    word_d.sel  = timer_sel_i;
    word_d.duty = duty_c;
    word_d.quo  = '0;
    word_d.dsh  = {freq_c, {(QUO_W-1){1'b0}}};
    if (freq_c <= FREQ_W'(BAND0_TOP)) begin
      word_d.psc = PSC_W'(PSC_BAND0);
      word_d.rem = NUM_W'(NUM_BAND0);
    end else if (freq_c <= FREQ_W'(BAND1_TOP)) begin
      word_d.psc = PSC_W'(PSC_BAND1);
      word_d.rem = NUM_W'(NUM_BAND1);
    end else if (freq_c <= FREQ_W'(BAND2_TOP)) begin
      word_d.psc = PSC_W'(PSC_BAND2);
      word_d.rem = NUM_W'(NUM_BAND2);
    end else begin
      word_d.psc = PSC_W'(PSC_BAND3);
      word_d.rem = NUM_W'(NUM_BAND3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule : ptsc_front

>>> rtl/ptsc_div_cell.sv
// ptsc_div_cell: one restoring division step, one quotient bit per cell
// depends on ptsc_pkg
`timescale 1ns / 1ps

module ptsc_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  ptsc_pkg::ptsc_word_t word_i,
  output logic                 valid_o,
  output ptsc_pkg::ptsc_word_t word_o
);
  import ptsc_pkg::*;

  ptsc_word_t word_d, word_q;
  logic       valid_q;
  logic       fits;

  always_comb begin
    // shifted divisor fits into the remainder: take the bit
    fits   = {{(DSH_W-NUM_W){1'b0}}, word_i.rem} >= word_i.dsh;
    word_d = word_i;
    word_d.dsh = word_i.dsh >> 1;
    word_d.quo = {word_i.quo[QUO_W-2:0], fits};
    if (fits) begin
      word_d.rem = word_i.rem - word_i.dsh[NUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule : ptsc_div_cell

>>> rtl/ptsc_back.sv
// ptsc_back: period floor, duty product and divide by 100, with the output register
// depends on ptsc_pkg
`timescale 1ns / 1ps

module ptsc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  ptsc_pkg::ptsc_word_t            word_i,
  output logic                            done_o,
  output logic [ptsc_pkg::SEL_W-1:0]      timer_out_sel_o,
  output logic [ptsc_pkg::PSC_W-1:0]      prescale_value_o,
  output logic [ptsc_pkg::PERIOD_W-1:0]   period_value_o,
  output logic [ptsc_pkg::CMP_W-1:0]      compare_value_o
);
  import ptsc_pkg::*;

  logic [QUO_W-1:0]    quo_m1;
  logic [PERIOD_W-1:0] period_d;
  logic [PROD_W-1:0]   prod_d;
  logic [RMUL_W-1:0]   rmul;

  logic                valid_a_q, valid_b_q;
  logic [SEL_W-1:0]    sel_a_q, sel_b_q;
  logic [PSC_W-1:0]    psc_a_q, psc_b_q;
  logic [PERIOD_W-1:0] period_a_q, period_b_q;
  logic [PROD_W-1:0]   prod_a_q;
  logic [CMP_W-1:0]    cmp_b_q;

  always_comb begin
    quo_m1   = word_i.quo - QUO_W'(1);
    period_d = (quo_m1 < QUO_W'(PERIOD_MIN)) ? PERIOD_W'(PERIOD_MIN) : quo_m1[PERIOD_W-1:0];
    prod_d   = PROD_W'(period_d) * PROD_W'(word_i.duty);
    // reciprocal multiply stands in for the divide by 100
    rmul     = RMUL_W'(prod_a_q) * RMUL_W'(RECIP_M);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sel_a_q    <= word_i.sel;
      psc_a_q    <= word_i.psc;
      period_a_q <= period_d;
      prod_a_q   <= prod_d;
    end
    if (valid_a_q) begin
      sel_b_q    <= sel_a_q;
      psc_b_q    <= psc_a_q;
      period_b_q <= period_a_q;
      cmp_b_q    <= rmul[RECIP_SH +: CMP_W];
    end
  end

  assign done_o           = valid_b_q;
  assign timer_out_sel_o  = sel_b_q;
  assign prescale_value_o = psc_b_q;
  assign period_value_o   = period_b_q;
  assign compare_value_o  = cmp_b_q;

endmodule : ptsc_back

>>> rtl/ptsc_checker.sv
// ptsc_checker: port-level checks on the pwm timer setting calculator
// depends on ptsc_pkg; bound to pwm_timer_setting_calculator_top
`timescale 1ns / 1ps

module ptsc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic [ptsc_pkg::SEL_W-1:0]          timer_sel_i,
  input logic                                done_o,
  input logic [ptsc_pkg::SEL_W-1:0]          timer_out_sel_o,
  input logic [ptsc_pkg::PSC_W-1:0]          prescale_value_o,
  input logic [ptsc_pkg::PERIOD_W-1:0]       period_value_o,
  input logic [ptsc_pkg::CMP_W-1:0]          compare_value_o
);
  import ptsc_pkg::*;

  localparam int unsigned LAT = DIV_STEPS + 3;

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("result missing after request");

  // no result without a request at the matching edge, and the select travels with it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start, LAT) && $past(timer_sel_i, LAT) == timer_out_sel_o))
    else $error("result without matching request");

  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (period_value_o >= PERIOD_W'(PERIOD_MIN) && compare_value_o <= period_value_o))
    else $error("period or compare out of range");

  a_psc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (prescale_value_o == PSC_W'(PSC_BAND0) || prescale_value_o == PSC_W'(PSC_BAND1)
             || prescale_value_o == PSC_W'(PSC_BAND2) || prescale_value_o == PSC_W'(PSC_BAND3)))
    else $error("prescaler not a band value");

endmodule : ptsc_checker

bind pwm_timer_setting_calculator_top ptsc_checker u_ptsc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .timer_sel_i      (timer_sel_i),
  .done_o           (done_o),
  .timer_out_sel_o  (timer_out_sel_o),
  .prescale_value_o (prescale_value_o),
  .period_value_o   (period_value_o),
  .compare_value_o  (compare_value_o)
);

>>> verif/ptsc_result_checker.sv
// ptsc_result_checker: works out the expected prescaler, period and compare for each request
// taken by the block and compares every result word against them in order
// depends on ptsc_pkg for field widths and timer constants
`timescale 1ns / 1ps

module ptsc_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [ptsc_pkg::SEL_W-1:0]     timer_sel_i,
  input  logic [ptsc_pkg::FREQ_IN_W-1:0] freq_request_i,
  input  logic [ptsc_pkg::DUTY_IN_W-1:0] duty_request_i,
  input  logic                           done_i,
  input  logic [ptsc_pkg::SEL_W-1:0]     timer_out_sel_i,
  input  logic [ptsc_pkg::PSC_W-1:0]     prescale_value_i,
  input  logic [ptsc_pkg::PERIOD_W-1:0]  period_value_i,
  input  logic [ptsc_pkg::CMP_W-1:0]     compare_value_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);

  import ptsc_pkg::*;

  typedef struct packed {
    logic [SEL_W-1:0]    sel;
    logic [PSC_W-1:0]    psc;
    logic [PERIOD_W-1:0] period;
    logic [CMP_W-1:0]    cmp;
  } timer_setting_t;

  timer_setting_t pending_settings[$];
  timer_setting_t want;
  int unsigned    n_mismatch;

  function automatic timer_setting_t compute_timer_setting(
    logic [SEL_W-1:0]     sel,
    logic [FREQ_IN_W-1:0] freq_req,
    logic [DUTY_IN_W-1:0] duty_req
  );
    int unsigned    freq;
    int unsigned    duty;
    int unsigned    psc;
    int unsigned    period;
    int unsigned    cmp;
    timer_setting_t setting;
    freq = 32'(freq_req);
    duty = 32'(duty_req);
    if (freq < 1) freq = 1;
    if (freq > FREQ_MAX) freq = FREQ_MAX;
    if (duty > DUTY_MAX) duty = DUTY_MAX;
    if (freq <= BAND0_TOP) psc = PSC_BAND0;
    else if (freq <= BAND1_TOP) psc = PSC_BAND1;
    else if (freq <= BAND2_TOP) psc = PSC_BAND2;
    else psc = PSC_BAND3;
    period = (CLOCK_HZ / (psc + 1)) / freq - 1;
    if (period < PERIOD_MIN) period = PERIOD_MIN;
    // duty is a percentage of the period
    cmp = period * duty / DUTY_MAX;
    setting.sel    = sel;
    setting.psc    = psc[PSC_W-1:0];
    setting.period = period[PERIOD_W-1:0];
    setting.cmp    = cmp[CMP_W-1:0];
    return setting;
  endfunction

  task automatic check_field(string field, int unsigned expected, int unsigned actual);
    if (expected !== actual) begin
      $error("%s: expected %0d, actual %0d", field, expected, actual);
      n_mismatch++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_settings.delete();
      n_mismatch = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      // retire before taking the new request, so a word never meets its own result
      if (done_i) begin
        if (pending_settings.size() == 0) begin
          $error("result word with no request outstanding");
          n_mismatch++;
        end else begin
          want = pending_settings.pop_front();
          check_field("timer_out_sel", 32'(want.sel), 32'(timer_out_sel_i));
          check_field("prescale_value", 32'(want.psc), 32'(prescale_value_i));
          check_field("period_value", 32'(want.period), 32'(period_value_i));
          check_field("compare_value", 32'(want.cmp), 32'(compare_value_i));
        end
      end
      if (start_i && !busy_i) begin
        pending_settings.push_back(
          compute_timer_setting(timer_sel_i, freq_request_i, duty_request_i));
      end
      mismatch_count_o <= n_mismatch;
      pending_o        <= pending_settings.size();
    end
  end

endmodule : ptsc_result_checker

>>> verif/tb.sv
// tb: stimulus and verdict for the pwm timer setting calculator
// depends on ptsc_pkg, pwm_timer_setting_calculator_top and ptsc_result_checker
`timescale 1ns / 1ps

module tb;

  import ptsc_pkg::*;

  // a quiet spell this long means a hang
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned RANDOM_WORDS   = 1150;
  localparam int unsigned GAP_PERCENT    = 25;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start  = 1'b0;
  logic                 busy;
  logic [SEL_W-1:0]     timer_sel_i    = '0;
  logic [FREQ_IN_W-1:0] freq_request_i = '0;
  logic [DUTY_IN_W-1:0] duty_request_i = '0;
  logic                 done_o;
  logic [SEL_W-1:0]     timer_out_sel_o;
  logic [PSC_W-1:0]     prescale_value_o;
  logic [PERIOD_W-1:0]  period_value_o;
  logic [CMP_W-1:0]     compare_value_o;

  int unsigned mismatch_count;
  int unsigned pending;

  // sender gaps on or off; switched off for a long stretch of the random part
  bit allow_gaps = 1'b1;

  always #1 clk_i = ~clk_i;

  pwm_timer_setting_calculator_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .timer_sel_i      (timer_sel_i),
    .freq_request_i   (freq_request_i),
    .duty_request_i   (duty_request_i),
    .done_o           (done_o),
    .timer_out_sel_o  (timer_out_sel_o),
    .prescale_value_o (prescale_value_o),
    .period_value_o   (period_value_o),
    .compare_value_o  (compare_value_o)
  );

  ptsc_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .timer_sel_i      (timer_sel_i),
    .freq_request_i   (freq_request_i),
    .duty_request_i   (duty_request_i),
    .done_i           (done_o),
    .timer_out_sel_i  (timer_out_sel_o),
    .prescale_value_i (prescale_value_o),
    .period_value_i   (period_value_o),
    .compare_value_i  (compare_value_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // offer one request word and return at the edge that takes it;
  // start stays high from one word to the next unless a gap is drawn
  task automatic send_request(
    logic [SEL_W-1:0]     sel,
    logic [FREQ_IN_W-1:0] freq,
    logic [DUTY_IN_W-1:0] duty
  );
    while (allow_gaps && $urandom_range(99) < GAP_PERCENT) begin
      // junk on the payload while start is low, it must be ignored
      start          <= 1'b0;
      timer_sel_i    <= SEL_W'($urandom);
      freq_request_i <= FREQ_IN_W'($urandom);
      duty_request_i <= DUTY_IN_W'($urandom);
      @(posedge clk_i);
    end
    start          <= 1'b1;
    timer_sel_i    <= sel;
    freq_request_i <= freq;
    duty_request_i <= duty;
    do @(posedge clk_i); while (busy);
  endtask

  // frequency mostly spread over the four bands, some over the whole field
  function automatic logic [FREQ_IN_W-1:0] pick_freq();
    int unsigned freq;
    case ($urandom_range(9))
      0, 1: freq = $urandom;
      2: begin
        case ($urandom_range(9))
          0: freq = 0;
          1: freq = 1;
          2: freq = BAND0_TOP;
          3: freq = BAND0_TOP + 1;
          4: freq = BAND1_TOP;
          5: freq = BAND1_TOP + 1;
          6: freq = BAND2_TOP;
          7: freq = BAND2_TOP + 1;
          8: freq = FREQ_MAX;
          default: freq = FREQ_MAX + 1;
        endcase
      end
      3: freq = $urandom_range(BAND0_TOP, 1);
      4: freq = $urandom_range(BAND1_TOP, BAND0_TOP + 1);
      5: freq = $urandom_range(BAND2_TOP, BAND1_TOP + 1);
      6, 7: freq = $urandom_range(FREQ_MAX, BAND2_TOP + 1);
      // top of the last band, part of which gets the period floored
      8: freq = $urandom_range(FREQ_MAX, 80000);
      default: freq = $urandom_range(FREQ_MAX, 0);
    endcase
    return FREQ_IN_W'(freq);
  endfunction

  function automatic logic [DUTY_IN_W-1:0] pick_duty();
    int unsigned duty;
    case ($urandom_range(4))
      0, 1, 4: duty = $urandom_range(DUTY_MAX, 0);
      2: duty = $urandom;
      default: begin
        case ($urandom_range(5))
          0: duty = 0;
          1: duty = 1;
          2: duty = DUTY_MAX - 1;
          3: duty = DUTY_MAX;
          4: duty = DUTY_MAX + 1;
          default: duty = 255;
        endcase
      end
    endcase
    return DUTY_IN_W'(duty);
  endfunction

  // watchdog: ends the run if no word moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words: band edges, clamps, duty extremes and the period floor
    send_request(1'b0, 20'd0, 8'd0);         // zero frequency taken as 1 Hz
    send_request(1'b1, 20'd1, 8'd100);
    send_request(1'b0, 20'd100, 8'd50);      // top of the slowest band
    send_request(1'b1, 20'd101, 8'd101);     // duty just over full scale
    send_request(1'b0, 20'd1000, 8'd255);
    send_request(1'b1, 20'd1001, 8'd1);
    send_request(1'b0, 20'd10000, 8'd99);
    send_request(1'b1, 20'd10001, 8'd100);
    send_request(1'b0, 20'd89000, 8'd50);    // short period, landing right on the floor
    send_request(1'b1, 20'd90000, 8'd100);
    send_request(1'b0, 20'd100000, 8'd100);
    send_request(1'b1, 20'd100001, 8'd37);   // frequency clamped to the maximum
    send_request(1'b0, 20'hFFFFF, 8'hFF);
    send_request(1'b1, 20'hAAAAA, 8'h55);
    send_request(1'b0, 20'h55555, 8'hAA);
    send_request(1'b1, 20'd7, 8'd33);
    send_request(1'b0, 20'd333, 8'd67);
    send_request(1'b1, 20'd4321, 8'd0);
    send_request(1'b0, 20'd55555, 8'd100);

    // random words, with a long back-to-back stretch in the middle
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      allow_gaps = !(n >= 400 && n < 700);
      send_request(SEL_W'($urandom), pick_freq(), pick_duty());
    end
    start <= 1'b0;

    // let the row drain, then give any stray result time to show
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule : tb
